FILE: src/lpqd_pkg.sv
// Shared types, codes and constants of the linear-prediction decoder.
package lpqd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIFF = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_TS = 8'd1;

	localparam logic [63:0] DOUBLE_TWO         = 64'h4000_0000_0000_0000;
	localparam logic [63:0] DOUBLE_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

	typedef logic [2:0] fp_op_t;
	localparam fp_op_t FP_CVT = 3'd0;
	localparam fp_op_t FP_ADD = 3'd1;
	localparam fp_op_t FP_SUB = 3'd2;
	localparam fp_op_t FP_MUL = 3'd3;
	localparam fp_op_t FP_DIV = 3'd4;

	typedef struct packed {
		fp_op_t      op;
		logic [63:0] a;
		logic [63:0] b;
	} fp_req_t;

	typedef struct packed {
		logic        block_start;
		logic [63:0] time_step;
		logic [63:0] residual;
	} lpqd_item_t;

endpackage

FILE: src/lpqd_if.sv
// Channel interfaces: input points, result items and configuration writes.
interface lpqd_point_if;
	logic               valid;
	logic               ready;
	logic               block_start;
	logic signed [63:0] time_step;
	logic        [63:0] residual_code;
	modport source(output valid, block_start, time_step, residual_code, input ready);
	modport sink(input valid, block_start, time_step, residual_code, output ready);
endinterface

interface lpqd_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic [63:0] point_timestamp;
	modport source(output valid, value_bits, point_timestamp, input ready);
	modport sink(input valid, value_bits, point_timestamp, output ready);
endinterface

interface lpqd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lpqd_pkg::CFG_INDEX_W-1:0]   index;
	logic [63:0]                        data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/lpqd_front.sv
// Front end: take point transfers, undo the zigzag code and hand items to the queue.
module lpqd_front (
	lpqd_point_if.sink             point,
	output lpqd_pkg::lpqd_item_t   push_item,
	output logic                   push_valid,
	input  logic                   push_ready
);

	logic [63:0] code;

	assign code       = point.residual_code;
	assign push_valid = point.valid;
	assign point.ready = push_ready;

	always_comb begin
		push_item.block_start = point.block_start;
		push_item.time_step   = point.time_step;
		// zigzag: even codes are non-negative, odd codes negative
		push_item.residual    = {1'b0, code[63:1]} ^ {64{code[0]}};
	end

endmodule

FILE: src/lpqd_queue.sv
// Short item queue between front and back end.
module lpqd_queue #(
	parameter int unsigned DEPTH = lpqd_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  lpqd_pkg::lpqd_item_t  push_item,
	output logic                  push_ready,
	output logic                  pop_valid,
	output lpqd_pkg::lpqd_item_t  pop_item,
	input  logic                  pop_ready
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	lpqd_pkg::lpqd_item_t entry_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: src/lpqd_fpu.sv
// Shared iterative double-precision unit: convert, add, subtract, multiply, divide.
module lpqd_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lpqd_pkg::fp_req_t req,
	output logic              busy,
	output logic              done,
	output logic [63:0]       result
);

	localparam logic [3:0] F_IDLE    = 4'd0;
	localparam logic [3:0] F_ALIGN   = 4'd1;
	localparam logic [3:0] F_ADD     = 4'd2;
	localparam logic [3:0] F_MUL     = 4'd3;
	localparam logic [3:0] F_PRENORM = 4'd4;
	localparam logic [3:0] F_DIV     = 4'd5;
	localparam logic [3:0] F_NORM    = 4'd6;
	localparam logic [3:0] F_DENORM  = 4'd7;
	localparam logic [3:0] F_ROUND   = 4'd8;
	localparam logic [3:0] F_DONE    = 4'd9;

	localparam logic signed [13:0] EMIN   = -14'sd1022;
	localparam logic signed [13:0] EMAX   = 14'sd1023;
	localparam logic signed [13:0] EFLUSH = -14'sd1150;
	localparam logic [63:0] QUIET = 64'h0008_0000_0000_0000;

	logic [3:0]         state_q;
	logic               sa_q, sb_q, s_q, st_q;
	logic signed [13:0] ea_q, eb_q, e_q;
	logic [52:0]        ma_q, mb_q;
	logic [127:0]       m_q;
	logic [53:0]        rem_q;
	logic [5:0]         cnt_q;
	logic [63:0]        res_q;

	// operand unpacking
	logic [10:0]        a_exp, b_exp;
	logic [52:0]        a_sig, b_sig;
	logic signed [13:0] a_e, b_e;
	logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_s;
	logic [63:0]        mag;

	assign a_exp  = req.a[62:52];
	assign b_exp  = req.b[62:52];
	assign a_sig  = {a_exp != 11'd0, req.a[51:0]};
	assign b_sig  = {b_exp != 11'd0, req.b[51:0]};
	assign a_e    = (a_exp == 11'd0) ? EMIN : $signed({3'b000, a_exp}) - 14'sd1023;
	assign b_e    = (b_exp == 11'd0) ? EMIN : $signed({3'b000, b_exp}) - 14'sd1023;
	assign a_nan  = (&a_exp) && (|req.a[51:0]);
	assign b_nan  = (&b_exp) && (|req.b[51:0]);
	assign a_inf  = (&a_exp) && !(|req.a[51:0]);
	assign b_inf  = (&b_exp) && !(|req.b[51:0]);
	assign a_zero = (req.a[62:0] == 63'd0);
	assign b_zero = (req.b[62:0] == 63'd0);
	assign b_s    = req.b[63] ^ (req.op == lpqd_pkg::FP_SUB);
	assign mag    = req.a[63] ? (~req.a + 64'd1) : req.a;

	// alignment shift
	logic signed [13:0] d;
	logic [127:0]       bm, bal;
	logic               jam;
	always_comb begin
		d   = ea_q - eb_q;
		bm  = {1'b0, mb_q, 74'd0};
		if (d > 14'sd127) begin
			bal = '0;
			jam = |mb_q;
		end else begin
			bal = bm >> d[6:0];
			jam = ((bal << d[6:0]) != bm);
		end
	end

	// add / subtract
	logic [127:0] am, addsum;
	assign am     = {1'b0, ma_q, 74'd0};
	assign addsum = (sa_q == sb_q) ? am + m_q : am - m_q;

	// partial products, one a cycle
	logic [26:0]  px, py;
	logic [6:0]   psh;
	logic [53:0]  prod;
	logic [127:0] prod_sh;
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				px  = ma_q[26:0];
				py  = mb_q[26:0];
				psh = 7'd22;
			end
			2'd1: begin
				px  = {1'b0, ma_q[52:27]};
				py  = mb_q[26:0];
				psh = 7'd49;
			end
			2'd2: begin
				px  = ma_q[26:0];
				py  = {1'b0, mb_q[52:27]};
				psh = 7'd49;
			end
			default: begin
				px  = {1'b0, ma_q[52:27]};
				py  = {1'b0, mb_q[52:27]};
				psh = 7'd76;
			end
		endcase
		prod    = px * py;
		prod_sh = {74'd0, prod} << psh;
	end

	// two restoring division steps
	logic [54:0] r1, r1n, r2, r2n;
	logic        q1, q2;
	always_comb begin
		r1  = {rem_q, m_q[127]};
		q1  = (r1 >= {2'b00, mb_q});
		r1n = q1 ? r1 - {2'b00, mb_q} : r1;
		r2  = {r1n[53:0], m_q[126]};
		q2  = (r2 >= {2'b00, mb_q});
		r2n = q2 ? r2 - {2'b00, mb_q} : r2;
	end

	// rounding to nearest even and packing
	logic [52:0]        mant, mant_r;
	logic [53:0]        rsum;
	logic               rg, rstk, rinc;
	logic signed [13:0] er, ebias;
	logic [63:0]        packed_res;
	always_comb begin
		mant  = m_q[127:75];
		rg    = m_q[74];
		rstk  = (|m_q[73:0]) | st_q;
		rinc  = rg & (rstk | mant[0]);
		rsum  = {1'b0, mant} + {53'd0, rinc};
		if (rsum[53]) begin
			mant_r = rsum[53:1];
			er     = e_q + 14'sd1;
		end else begin
			mant_r = rsum[52:0];
			er     = e_q;
		end
		ebias = er + 14'sd1023;
		if (er > EMAX) begin
			packed_res = {s_q, 11'h7FF, 52'd0};
		end else begin
			packed_res = {s_q, mant_r[52] ? ebias[10:0] : 11'd0, mant_r[51:0]};
		end
	end

	logic signed [13:0] dn;
	assign dn = EMIN - e_q;

	assign busy   = (state_q != F_IDLE);
	assign done   = (state_q == F_DONE);
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						case (req.op)
							lpqd_pkg::FP_CVT: begin
								s_q     <= req.a[63];
								m_q     <= {mag, 64'd0};
								e_q     <= 14'sd63;
								st_q    <= 1'b0;
								state_q <= F_NORM;
							end
							lpqd_pkg::FP_ADD, lpqd_pkg::FP_SUB: begin
								state_q <= F_DONE;
								if (a_nan) begin
									res_q <= req.a | QUIET;
								end else if (b_nan) begin
									res_q <= req.b | QUIET;
								end else if (a_inf && b_inf) begin
									res_q <= (req.a[63] == b_s) ? req.a
										: lpqd_pkg::DOUBLE_DEFAULT_NAN;
								end else if (a_inf) begin
									res_q <= req.a;
								end else if (b_inf) begin
									res_q <= {b_s, req.b[62:0]};
								end else if (req.b[62:0] > req.a[62:0]) begin
									sa_q <= b_s;       ea_q <= b_e; ma_q <= b_sig;
									sb_q <= req.a[63]; eb_q <= a_e; mb_q <= a_sig;
									state_q <= F_ALIGN;
								end else begin
									sa_q <= req.a[63]; ea_q <= a_e; ma_q <= a_sig;
									sb_q <= b_s;       eb_q <= b_e; mb_q <= b_sig;
									state_q <= F_ALIGN;
								end
							end
							lpqd_pkg::FP_MUL: begin
								s_q     <= req.a[63] ^ req.b[63];
								state_q <= F_DONE;
								if (a_nan) begin
									res_q <= req.a | QUIET;
								end else if (b_nan) begin
									res_q <= req.b | QUIET;
								end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
									res_q <= lpqd_pkg::DOUBLE_DEFAULT_NAN;
								end else if (a_inf || b_inf) begin
									res_q <= {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
								end else begin
									ma_q    <= a_sig;
									mb_q    <= b_sig;
									e_q     <= a_e + b_e + 14'sd1;
									m_q     <= '0;
									st_q    <= 1'b0;
									cnt_q   <= '0;
									state_q <= F_MUL;
								end
							end
							lpqd_pkg::FP_DIV: begin
								s_q     <= req.a[63] ^ req.b[63];
								state_q <= F_DONE;
								if (a_nan) begin
									res_q <= req.a | QUIET;
								end else if (b_nan) begin
									res_q <= req.b | QUIET;
								end else if ((a_zero && b_zero) || (a_inf && b_inf)) begin
									res_q <= lpqd_pkg::DOUBLE_DEFAULT_NAN;
								end else if (a_inf || b_zero) begin
									res_q <= {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
								end else if (a_zero || b_inf) begin
									res_q <= {req.a[63] ^ req.b[63], 63'd0};
								end else begin
									ma_q    <= a_sig;
									mb_q    <= b_sig;
									ea_q    <= a_e;
									eb_q    <= b_e;
									state_q <= F_PRENORM;
								end
							end
							default: begin
								res_q   <= lpqd_pkg::DOUBLE_DEFAULT_NAN;
								state_q <= F_DONE;
							end
						endcase
					end
				end
				F_ALIGN: begin
					m_q     <= bal | {127'd0, jam};
					state_q <= F_ADD;
				end
				F_ADD: begin
					m_q     <= addsum;
					e_q     <= ea_q + 14'sd1;
					s_q     <= (addsum == '0) ? (sa_q & sb_q) : sa_q;
					st_q    <= 1'b0;
					state_q <= F_NORM;
				end
				F_MUL: begin
					m_q   <= m_q + prod_sh;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= F_NORM;
					end
				end
				F_PRENORM: begin
					// bring both significands to a leading one at bit 52
					if (!ma_q[52]) begin
						if (ma_q[52:45] == 8'd0) begin
							ma_q <= ma_q << 8;
							ea_q <= ea_q - 14'sd8;
						end else begin
							ma_q <= ma_q << 1;
							ea_q <= ea_q - 14'sd1;
						end
					end
					if (!mb_q[52]) begin
						if (mb_q[52:45] == 8'd0) begin
							mb_q <= mb_q << 8;
							eb_q <= eb_q - 14'sd8;
						end else begin
							mb_q <= mb_q << 1;
							eb_q <= eb_q - 14'sd1;
						end
					end
					if (ma_q[52] && mb_q[52]) begin
						m_q     <= {1'b0, ma_q, 74'd0};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					m_q   <= {m_q[125:0], q1, q2};
					rem_q <= r2n[53:0];
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						st_q    <= (r2n != '0);
						e_q     <= ea_q - eb_q + 14'sd53;
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (m_q == '0 || m_q[127]) begin
						state_q <= F_DENORM;
					end else if (m_q[127:112] == 16'd0) begin
						m_q <= m_q << 16;
						e_q <= e_q - 14'sd16;
					end else begin
						m_q <= m_q << 1;
						e_q <= e_q - 14'sd1;
					end
				end
				F_DENORM: begin
					// shift down into the subnormal range, folding lost bits into sticky
					if (e_q >= EMIN) begin
						state_q <= F_ROUND;
					end else if (e_q < EFLUSH) begin
						st_q <= st_q | (|m_q);
						m_q  <= '0;
						e_q  <= EMIN;
					end else if (dn >= 14'sd16) begin
						st_q <= st_q | (|m_q[15:0]);
						m_q  <= m_q >> 16;
						e_q  <= e_q + 14'sd16;
					end else begin
						st_q <= st_q | m_q[0];
						m_q  <= m_q >> 1;
						e_q  <= e_q + 14'sd1;
					end
				end
				F_ROUND: begin
					res_q   <= packed_res;
					state_q <= F_DONE;
				end
				F_DONE: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/lpqd_back.sv
// Back end: prediction sequencer over the shared unit, history and result register.
module lpqd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  lpqd_pkg::lpqd_item_t  pop_item,
	output logic                  pop_ready,
	input  logic [63:0]           max_diff_bits,
	input  logic [63:0]           start_timestamp,
	lpqd_result_if.source         result
);

	localparam logic [3:0] B_IDLE   = 4'd0;
	localparam logic [3:0] B_QUANT  = 4'd1;
	localparam logic [3:0] B_RESID  = 4'd2;
	localparam logic [3:0] B_OFFSET = 4'd3;
	localparam logic [3:0] B_RISE   = 4'd4;
	localparam logic [3:0] B_GAP1   = 4'd5;
	localparam logic [3:0] B_SLOPE  = 4'd6;
	localparam logic [3:0] B_GAP2   = 4'd7;
	localparam logic [3:0] B_STEP   = 4'd8;
	localparam logic [3:0] B_PRED   = 4'd9;
	localparam logic [3:0] B_TWICE  = 4'd10;
	localparam logic [3:0] B_PRED2  = 4'd11;
	localparam logic [3:0] B_VALUE  = 4'd12;
	localparam logic [3:0] B_OUT    = 4'd13;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_LATER  = 2'd2;

	logic [3:0]  state_q, next_state;
	logic        issued_q, is_op;
	logic [1:0]  phase_q;
	logic [63:0] lv_q, ov_q, lt_q, ot_q;
	logic [63:0] now_q, resid_int_q, gap1_q, gap2_q;
	logic        direct_q, linear_q, restart_q;
	logic [63:0] quant_q, resid_q, offset_q, tmp_q, gap_q, pred_q, value_q;
	logic        out_valid_q;
	logic [63:0] out_value_q, out_ts_q;
	logic        commit;

	lpqd_pkg::fp_req_t fp_req;
	logic              fp_start, fp_busy, fp_done;
	logic [63:0]       fp_result;

	// classification of a popped item against the history
	logic        restart, linear;
	logic [63:0] now, gap1, gap2;
	always_comb begin
		restart = pop_item.block_start || (phase_q == PH_FIRST);
		now     = restart ? start_timestamp : lt_q + pop_item.time_step;
		gap1    = lt_q - ot_q;
		gap2    = now - lt_q;
		linear  = (now != 64'd0) && (lt_q != 64'd0) && (ot_q != 64'd0)
			&& !gap1[63] && (gap1 != 64'd0) && !gap2[63] && (gap2 != 64'd0);
	end

	always_comb begin
		fp_req     = '{op: lpqd_pkg::FP_ADD, a: pred_q, b: offset_q};
		is_op      = 1'b1;
		next_state = B_IDLE;
		case (state_q)
			B_QUANT: begin
				fp_req     = '{op: lpqd_pkg::FP_MUL, a: lpqd_pkg::DOUBLE_TWO, b: max_diff_bits};
				next_state = B_RESID;
			end
			B_RESID: begin
				fp_req     = '{op: lpqd_pkg::FP_CVT, a: resid_int_q, b: 64'd0};
				next_state = B_OFFSET;
			end
			B_OFFSET: begin
				fp_req     = '{op: lpqd_pkg::FP_MUL, a: quant_q, b: resid_q};
				next_state = direct_q ? B_VALUE : (linear_q ? B_RISE : B_TWICE);
			end
			B_RISE: begin
				fp_req     = '{op: lpqd_pkg::FP_SUB, a: lv_q, b: ov_q};
				next_state = B_GAP1;
			end
			B_GAP1: begin
				fp_req     = '{op: lpqd_pkg::FP_CVT, a: gap1_q, b: 64'd0};
				next_state = B_SLOPE;
			end
			B_SLOPE: begin
				fp_req     = '{op: lpqd_pkg::FP_DIV, a: tmp_q, b: gap_q};
				next_state = B_GAP2;
			end
			B_GAP2: begin
				fp_req     = '{op: lpqd_pkg::FP_CVT, a: gap2_q, b: 64'd0};
				next_state = B_STEP;
			end
			B_STEP: begin
				fp_req     = '{op: lpqd_pkg::FP_MUL, a: tmp_q, b: gap_q};
				next_state = B_PRED;
			end
			B_PRED: begin
				fp_req     = '{op: lpqd_pkg::FP_ADD, a: lv_q, b: tmp_q};
				next_state = B_VALUE;
			end
			B_TWICE: begin
				fp_req     = '{op: lpqd_pkg::FP_MUL, a: lpqd_pkg::DOUBLE_TWO, b: lv_q};
				next_state = B_PRED2;
			end
			B_PRED2: begin
				fp_req     = '{op: lpqd_pkg::FP_SUB, a: tmp_q, b: ov_q};
				next_state = B_VALUE;
			end
			B_VALUE: begin
				next_state = B_OUT;
			end
			default: begin
				is_op = 1'b0;
			end
		endcase
	end

	assign fp_start     = is_op && !issued_q && !fp_busy;
	assign pop_ready    = (state_q == B_IDLE);
	assign commit       = (state_q == B_OUT) && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.value_bits      = out_value_q;
	assign result.point_timestamp = out_ts_q;

	lpqd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fp_start),
		.req    (fp_req),
		.busy   (fp_busy),
		.done   (fp_done),
		.result (fp_result)
	);

	// operand and result registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			now_q       <= now;
			resid_int_q <= pop_item.residual;
			gap1_q      <= gap1;
			gap2_q      <= gap2;
			direct_q    <= restart || (phase_q == PH_SECOND);
			linear_q    <= linear;
			restart_q   <= restart;
			pred_q      <= restart ? lpqd_pkg::DOUBLE_TWO : lv_q;
		end
		if (fp_done) begin
			case (state_q)
				B_QUANT:  quant_q  <= fp_result;
				B_RESID:  resid_q  <= fp_result;
				B_OFFSET: offset_q <= fp_result;
				B_GAP1, B_GAP2: gap_q <= fp_result;
				B_PRED, B_PRED2: pred_q <= fp_result;
				B_VALUE:  value_q  <= fp_result;
				default:  tmp_q    <= fp_result;
			endcase
		end
		if (commit) begin
			out_value_q <= value_q;
			out_ts_q    <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			issued_q    <= 1'b0;
			phase_q     <= PH_FIRST;
			lv_q        <= lpqd_pkg::DOUBLE_TWO;
			ov_q        <= lpqd_pkg::DOUBLE_TWO;
			lt_q        <= 64'd0;
			ot_q        <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fp_start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_QUANT;
					end
				end
				B_OUT: begin
					// commit the point to the history as the result goes out
					if (commit) begin
						lv_q        <= value_q;
						lt_q        <= now_q;
						if (restart_q) begin
							ov_q    <= lpqd_pkg::DOUBLE_TWO;
							ot_q    <= 64'd0;
							phase_q <= PH_SECOND;
						end else begin
							ov_q    <= lv_q;
							ot_q    <= lt_q;
							phase_q <= PH_LATER;
						end
						state_q <= B_IDLE;
					end
				end
				default: begin
					if (fp_done) begin
						issued_q <= 1'b0;
						state_q  <= next_state;
					end
				end
			endcase
		end
	end

endmodule

FILE: src/linear_predict_quantized_decoder.sv
// Point transfer to result valid: first and second points of a block take the direct path, later
//   points the 2*v1-v2 fallback or linear extrapolation, each a longer chain of FPU ops; NaN or
//   infinity cut an op short, and subnormal results add shift passes.
// Throughput: one point at a time, the next starting as the result register loads; the shared
//   FPU limits it, its divider retiring two quotient bits a cycle.
// Reset (arst_n low, asynchronous): history 2.0 and time zero, next point opens a block,
//   both registers zero, queue and result register empty.
module linear_predict_quantized_decoder #(
	parameter int unsigned QUEUE_DEPTH = lpqd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	lpqd_point_if.sink    point,
	lpqd_result_if.source result,
	lpqd_cfg_if.sink      cfg
);

	logic [63:0] max_diff_q, start_ts_q;

	lpqd_pkg::lpqd_item_t push_item, pop_item;
	logic                 push_valid, push_ready, pop_valid, pop_ready;

	// Configuration writes always complete; an index outside the list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q <= 64'd0;
			start_ts_q <= 64'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				lpqd_pkg::REG_MAX_DIFF: max_diff_q <= cfg.data;
				lpqd_pkg::REG_START_TS: start_ts_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Front: decode the zigzag residual and push each transfer into the queue.
	lpqd_front u_front (
		.point      (point),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Queue: hold a few decoded points so the front keeps taking transfers
	// while the back is busy.
	lpqd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// Back: predict, reconstruct, advance the history and present the result.
	lpqd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_item        (pop_item),
		.pop_ready       (pop_ready),
		.max_diff_bits   (max_diff_q),
		.start_timestamp (start_ts_q),
		.result          (result)
	);

endmodule
